// ===== sv/lts8_pkg.sv =====
package lts8_pkg;

  localparam int unsigned PixW  = 18;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ThrW  = 25;
  localparam int unsigned BigW  = 320;
  localparam int unsigned NumK  = 256;

  typedef logic [ThrW-1:0] thr_t;
  typedef thr_t thr_tab_t [NumK];
  typedef logic [BigW-1:0] big_t;

  function automatic big_t big_pow(big_t b, int unsigned n);
    big_t r;
    r = big_t'(1);
    for (int unsigned i = 0; i < n; i++) begin
      r = r * b;
    end
    return r;
  endfunction

  // smallest quotient whose encoding reaches (k - 0.5)/255
  function automatic thr_t thr_one(int unsigned k, int unsigned fb);
    logic [63:0] one;
    logic [63:0] ql;
    logic [63:0] qmax;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    big_t rhs;
    big_t lhs;
    big_t p12;
    one  = 64'd1 << fb;
    ql   = (64'(2 * k - 1) * 64'd100 * one + 64'd658919) / 64'd658920;
    qmax = (64'd31308 * one) / 64'd10000000;
    if (ql <= qmax) begin
      return ql[ThrW-1:0];
    end
    p12 = big_pow(big_t'(10761), 12);
    rhs = big_pow(big_t'(40 * k + 541), 12) * big_pow(big_t'(one), 5);
    lo  = qmax + 64'd1;
    hi  = one;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      lhs = big_pow(big_t'(mid), 5) * p12;
      if (lhs >= rhs) begin
        hi = mid;
      end else begin
        lo = mid + 64'd1;
      end
    end
    return lo[ThrW-1:0];
  endfunction

  function automatic thr_tab_t srgb_thr_table(int unsigned fb);
    thr_tab_t t;
    t[0] = '0;
    for (int unsigned k = 1; k < NumK; k++) begin
      t[k] = thr_one(k, fb);
    end
    return t;
  endfunction

endpackage

// ===== sv/lts8_if.sv =====
interface lts8_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lts8_pkg::PixW-1:0]     red_linear;
  logic signed [lts8_pkg::PixW-1:0]     green_linear;
  logic signed [lts8_pkg::PixW-1:0]     blue_linear;
  logic signed [lts8_pkg::PixW-1:0]     alpha_linear;

  modport source (output valid, red_linear, green_linear, blue_linear, alpha_linear,
                  input ready);
  modport sink (input valid, red_linear, green_linear, blue_linear, alpha_linear,
                output ready);
endinterface

interface lts8_out_if;
  logic                        valid;
  logic                        ready;
  logic [lts8_pkg::ByteW-1:0]  red_byte;
  logic [lts8_pkg::ByteW-1:0]  green_byte;
  logic [lts8_pkg::ByteW-1:0]  blue_byte;
  logic [lts8_pkg::ByteW-1:0]  alpha_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, alpha_byte,
                  input ready);
  modport sink (input valid, red_byte, green_byte, blue_byte, alpha_byte,
                output ready);
endinterface

// ===== sv/lts8_lane.sv =====
module lts8_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic [FRAC_BITS+8:0]              en_i,
  input  logic signed [lts8_pkg::PixW-1:0]  color_i,
  input  logic [FRAC_BITS:0]                alpha_i,
  output logic [lts8_pkg::ByteW-1:0]        byte_o
);
  import lts8_pkg::*;

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned ND = FRAC_BITS;
  localparam int unsigned NE = ByteW;
  localparam int unsigned D  = 1 + ND + NE;
  localparam int unsigned XW = ((PixW > W) ? PixW : W) + 1;
  localparam thr_tab_t Thr = srgb_thr_table(FRAC_BITS);

  logic [W-1:0]         a_q    [ND];
  logic [W-1:0]         r_q    [ND];
  logic [FRAC_BITS-1:0] q_q    [D-1];
  logic                 zero_q [D];
  logic                 sat_q  [D];
  logic [ByteW-1:0]     b_q    [NE];

  logic signed [XW-1:0] c_x;
  logic signed [XW-1:0] a_x;
  logic                 zero0;
  logic                 sat0;

  assign c_x   = XW'(color_i);
  assign a_x   = $signed({{(XW-W){1'b0}}, alpha_i});
  assign zero0 = (alpha_i == '0) || (c_x <= 0);
  assign sat0  = (c_x >= a_x);

  // entry stage
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q[0]    <= alpha_i;
      r_q[0]    <= c_x[W-1:0];
      q_q[0]    <= '0;
      zero_q[0] <= zero0;
      sat_q[0]  <= sat0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 1; s <= ND; s++) begin : g_div
    logic [W:0] t;
    logic       ge;
    assign t    = {r_q[s-1], 1'b0};
    assign ge   = (t >= {1'b0, a_q[s-1]});
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        q_q[s]    <= {q_q[s-1][FRAC_BITS-2:0], ge};
        zero_q[s] <= zero_q[s-1];
        sat_q[s]  <= sat_q[s-1];
      end
    end
    if (s < ND) begin : g_carry
      logic [W:0] diff;
      assign diff = t - {1'b0, a_q[s-1]};
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          a_q[s] <= a_q[s-1];
          r_q[s] <= ge ? diff[W-1:0] : t[W-1:0];
        end
      end
    end
  end

  // byte search against boundary thresholds, one bit per stage
  for (genvar e = 0; e < NE; e++) begin : g_enc
    localparam int unsigned S = 1 + ND + e;
    logic [ByteW-1:0] bprev;
    logic [ByteW-1:0] cand;
    thr_t             thr;
    logic             hit;
    if (e == 0) begin : g_first
      assign bprev = '0;
    end else begin : g_next
      assign bprev = b_q[e-1];
    end
    assign cand = bprev | ByteW'(1 << (NE - 1 - e));
    assign thr  = Thr[cand];
    assign hit  = ({1'b0, q_q[S-1]} >= thr[FRAC_BITS:0]);
    always_ff @(posedge clk_i) begin
      if (en_i[S]) begin
        b_q[e]    <= hit ? cand : bprev;
        zero_q[S] <= zero_q[S-1];
        sat_q[S]  <= sat_q[S-1];
      end
    end
    if (S < D - 1) begin : g_q
      always_ff @(posedge clk_i) begin
        if (en_i[S]) begin
          q_q[S] <= q_q[S-1];
        end
      end
    end
  end

  always_comb begin
    if (zero_q[D-1]) begin
      byte_o = '0;
    end else if (sat_q[D-1]) begin
      byte_o = '1;
    end else begin
      byte_o = b_q[NE-1];
    end
  end

endmodule

// ===== sv/linear_premult_to_srgb8.sv =====
// pipeline: from input transaction to output valid a pixel passes the entry stage
// (which loads on the accepting edge), then FRAC_BITS divider stages,
// 8 threshold search stages and the output register
// throughput: one pixel per cycle unless the output stalls; three color lanes in parallel
// the pipeline compacts bubbles while the output stalls
// reset: asynchronous active low, clears all valid flags; no clearing pass
module linear_premult_to_srgb8 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lts8_in_if.sink     in_i,
  lts8_out_if.source  out_o
);
  import lts8_pkg::*;

  localparam int unsigned D  = FRAC_BITS + 9;
  localparam int unsigned AW = FRAC_BITS + 1;
  localparam int unsigned XW = ((PixW > AW) ? PixW : AW) + 1;
  localparam int unsigned MW = AW + ByteW;

  logic [D-1:0]     v_q, v_d;
  logic [D:0]       rdy;
  logic             out_v_q, out_v_d;
  logic [ByteW-1:0] ab_q [D];
  logic [ByteW-1:0] red_q, green_q, blue_q, alpha_q;
  logic [ByteW-1:0] red_l, green_l, blue_l;

  logic signed [XW-1:0] as_x;
  logic [AW-1:0]        a_c;
  logic [MW-1:0]        a_m;
  logic [ByteW-1:0]     ab0;

  assign as_x = XW'(in_i.alpha_linear);

  always_comb begin
    if (as_x <= 0) begin
      a_c = '0;
    end else if (as_x > $signed(XW'(1) <<< FRAC_BITS)) begin
      a_c = AW'(1) << FRAC_BITS;
    end else begin
      a_c = as_x[AW-1:0];
    end
  end

  assign a_m = (MW'(a_c) << ByteW) - MW'(a_c) + (MW'(1) << (FRAC_BITS - 1));
  assign ab0 = a_m[FRAC_BITS +: ByteW];

  always_comb begin
    rdy[D] = !out_v_q || out_o.ready;
    for (int i = D - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    v_d[0] = rdy[0] ? in_i.valid : v_q[0];
    for (int i = 1; i < D; i++) begin
      v_d[i] = rdy[i] ? v_q[i-1] : v_q[i];
    end
    out_v_d = rdy[D] ? v_q[D-1] : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ab_q[0] <= ab0;
    end
    for (int i = 1; i < D; i++) begin
      if (rdy[i]) begin
        ab_q[i] <= ab_q[i-1];
      end
    end
  end

  lts8_lane #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk_i   (clk_i),
    .en_i    (rdy[D-1:0]),
    .color_i (in_i.red_linear),
    .alpha_i (a_c),
    .byte_o  (red_l)
  );

  lts8_lane #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk_i   (clk_i),
    .en_i    (rdy[D-1:0]),
    .color_i (in_i.green_linear),
    .alpha_i (a_c),
    .byte_o  (green_l)
  );

  lts8_lane #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk_i   (clk_i),
    .en_i    (rdy[D-1:0]),
    .color_i (in_i.blue_linear),
    .alpha_i (a_c),
    .byte_o  (blue_l)
  );

  // merge lanes into output register
  always_ff @(posedge clk_i) begin
    if (rdy[D]) begin
      red_q   <= red_l;
      green_q <= green_l;
      blue_q  <= blue_l;
      alpha_q <= ab_q[D-1];
    end
  end

  assign in_i.ready       = rdy[0];
  assign out_o.valid      = out_v_q;
  assign out_o.red_byte   = red_q;
  assign out_o.green_byte = green_q;
  assign out_o.blue_byte  = blue_q;
  assign out_o.alpha_byte = alpha_q;

`ifndef SYNTH
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> v_q[0])
    else $error("input stalled with empty entry stage");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(v_q[D-1]))
    else $error("output transaction without a pixel in the last stage");

  a_last_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[D-1] && !rdy[D]) |=> v_q[D-1])
    else $error("last stage pixel dropped while output stalled");
`endif

endmodule

// ===== test/linear_premult_to_srgb8_tb.sv =====
module linear_premult_to_srgb8_tb;
  import lts8_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam longint unsigned One = 64'd1 << FracBits;
  localparam int unsigned DrainCycles = FracBits + 40;

  typedef struct packed {
    logic signed [PixW-1:0] red;
    logic signed [PixW-1:0] green;
    logic signed [PixW-1:0] blue;
    logic signed [PixW-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
  } srgb_t;

  typedef logic [255:0] wide_t;

  logic clk_i;
  logic rst_ni;

  lts8_in_if  in_bus ();
  lts8_out_if out_bus ();

  linear_premult_to_srgb8 #(.FRAC_BITS(FracBits)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  pixel_t pixels_to_send[$];
  srgb_t  srgb_expected[$];
  int     mismatches = 0;

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.red_linear   = '0;
    in_bus.green_linear = '0;
    in_bus.blue_linear  = '0;
    in_bus.alpha_linear = '0;
    out_bus.ready       = 1'b0;
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // does the encoding of q/one reach the byte boundary (k - 0.5)/255
  function automatic bit srgb_reaches(longint unsigned q, int unsigned k);
    wide_t lhs;
    wide_t rhs;
    if (q * 64'd10000000 <= 64'd31308 * One) begin
      return q * 64'd1292 * 64'd510 >= longint'(2 * k - 1) * 64'd100 * One;
    end
    lhs = wide_t'(1);
    rhs = wide_t'(1);
    for (int i = 0; i < 5; i++) lhs = lhs * wide_t'(q);
    for (int i = 0; i < 12; i++) lhs = lhs * wide_t'(10761);
    for (int i = 0; i < 12; i++) rhs = rhs * wide_t'(40 * k + 541);
    rhs = rhs << (5 * FracBits);
    return lhs >= rhs;
  endfunction

  function automatic logic [ByteW-1:0] straight_srgb_byte(logic signed [PixW-1:0] c,
                                                          longint unsigned a);
    longint unsigned q;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (a == 0 || c <= 0) return '0;
    q = (longint'(c) << FracBits) / a;
    if (q >= One) return 8'd255;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (srgb_reaches(q, mid)) lo = mid;
      else hi = mid - 1;
    end
    return lo[ByteW-1:0];
  endfunction

  function automatic srgb_t convert_pixel(pixel_t p);
    srgb_t r;
    longint unsigned a;
    longint unsigned ab;
    if (p.alpha <= 0) a = 0;
    else if (longint'(p.alpha) > One) a = One;
    else a = longint'(p.alpha);
    r.red   = straight_srgb_byte(p.red, a);
    r.green = straight_srgb_byte(p.green, a);
    r.blue  = straight_srgb_byte(p.blue, a);
    ab = (a * 255 + (One >> 1)) >> FracBits;
    r.alpha = ab[ByteW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", field, got, want);
    mismatches++;
  endtask

  // driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t nxt;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        srgb_expected.push_back(convert_pixel({in_bus.red_linear, in_bus.green_linear,
                                               in_bus.blue_linear, in_bus.alpha_linear}));
        void'(pixels_to_send.pop_front());
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the pending transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        nxt = pixels_to_send[0];
        in_bus.valid        <= 1'b1;
        in_bus.red_linear   <= nxt.red;
        in_bus.green_linear <= nxt.green;
        in_bus.blue_linear  <= nxt.blue;
        in_bus.alpha_linear <= nxt.alpha;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor with its own stall pattern
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    srgb_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (srgb_expected.size() == 0) begin
          report_mismatch("unexpected transaction", out_bus.red_byte, 0);
        end else begin
          want = srgb_expected.pop_front();
          if (out_bus.red_byte !== want.red)
            report_mismatch("red_byte", out_bus.red_byte, want.red);
          if (out_bus.green_byte !== want.green)
            report_mismatch("green_byte", out_bus.green_byte, want.green);
          if (out_bus.blue_byte !== want.blue)
            report_mismatch("blue_byte", out_bus.blue_byte, want.blue);
          if (out_bus.alpha_byte !== want.alpha)
            report_mismatch("alpha_byte", out_bus.alpha_byte, want.alpha);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: out_bus.ready <= ($urandom_range(0, 1) != 0);
        default: out_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic logic signed [PixW-1:0] rand_alpha();
    case ($urandom_range(0, 9))
      0: return -$signed(PixW'($urandom_range(0, 131072)));
      1: return '0;
      2: return PixW'(One);
      3: return PixW'($urandom_range(65537, 131071));
      4: return PixW'($urandom_range(1, 300));
      5: return PixW'($urandom);
      default: return PixW'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic signed [PixW-1:0] rand_color(logic signed [PixW-1:0] a);
    int unsigned amax;
    amax = (a > 0) ? int'(a) : 1;
    case ($urandom_range(0, 9))
      0: return PixW'($urandom);
      1: return '0;
      2: return -$signed(PixW'($urandom_range(1, 131072)));
      3: return PixW'(($urandom_range(150, 260) * amax) >> FracBits);
      4: return PixW'($urandom_range(amax, 131071));
      default: return PixW'($urandom_range(0, amax));
    endcase
  endfunction

  initial begin
    pixel_t p;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: alpha and color extremes, linear segment edge, saturation
    pixels_to_send.push_back({18'sd1000, 18'sd2000, 18'sd3000, 18'sd0});
    pixels_to_send.push_back({18'sd1000, 18'sd2000, 18'sd3000, -18'sd131072});
    pixels_to_send.push_back({18'sd131071, 18'sd65536, 18'sd32768, 18'sd131071});
    pixels_to_send.push_back({18'sd65536, 18'sd0, -18'sd1, 18'sd65536});
    pixels_to_send.push_back({-18'sd131072, 18'sd131071, 18'sd1, 18'sd65536});
    pixels_to_send.push_back({18'sd1, 18'sd1, 18'sd1, 18'sd1});
    pixels_to_send.push_back({18'sd2, 18'sd131071, 18'sd0, 18'sd1});
    pixels_to_send.push_back({18'sd205, 18'sd206, 18'sd204, 18'sd65536});
    pixels_to_send.push_back({18'sd1, 18'sd3, 18'sd6, 18'sd65536});
    pixels_to_send.push_back({18'sd65535, 18'sd65534, 18'sd32768, 18'sd65536});
    pixels_to_send.push_back({18'sd100, 18'sd101, 18'sd99, 18'sd32768});
    pixels_to_send.push_back({18'sd32767, 18'sd32768, 18'sd32769, 18'sd32768});
    pixels_to_send.push_back({18'sd12345, 18'sd54321, 18'sd777, 18'sd65537});
    pixels_to_send.push_back({18'sd300, 18'sd20000, 18'sd65535, 18'sd65535});
    pixels_to_send.push_back({18'sd128, 18'sd129, 18'sd257, 18'sd257});
    pixels_to_send.push_back({18'sd5, 18'sd50, 18'sd500, 18'sd65536});
    pixels_to_send.push_back({18'sd131071, 18'sd131071, 18'sd131071, -18'sd1});
    pixels_to_send.push_back({18'sd13107, 18'sd3277, 18'sd655, 18'sd1000});

    // let the pipeline drain completely before the random part
    wait (pixels_to_send.size() == 0 && srgb_expected.size() == 0);

    for (int i = 0; i < 1000; i++) begin
      p.alpha = rand_alpha();
      p.red   = rand_color(p.alpha);
      p.green = rand_color(p.alpha);
      p.blue  = rand_color(p.alpha);
      pixels_to_send.push_back(p);
    end

    wait (pixels_to_send.size() == 0 && srgb_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && srgb_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lts8_pkg.sv
sv/lts8_if.sv
sv/lts8_lane.sv
sv/linear_premult_to_srgb8.sv
test/linear_premult_to_srgb8_tb.sv
